/* hdl/bcmb_pkg.sv */
// ----------------------------------------------------------------------------
// bcmb_pkg: shared types and constants for the blink code and mode buttons
// Holds the item action codes, mode codes, register indexes, reset values
// and the mode LED pattern lookup.
// ----------------------------------------------------------------------------
package bcmb_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CODE_BITS_DEF = 8;

    localparam int NOW_W  = 32;
    localparam int CFG_W  = 16;
    localparam int CODE_W = 8;

    localparam logic [CFG_W-1:0] FAST_TOGGLE_RST = 16'd100;
    localparam logic [CFG_W-1:0] SLOW_TOGGLE_RST = 16'd250;
    localparam logic [CFG_W-1:0] GAP_RST         = 16'd1000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_MESSAGE = 2'd1,
        ACT_MODE    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        MODE_EXPLORE = 3'd0,
        MODE_TRY1    = 3'd1,
        MODE_TRY2    = 3'd2,
        MODE_TRY3    = 3'd3,
        MODE_RUN     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CFG_FAST_TOGGLE = 2'd0,
        CFG_SLOW_TOGGLE = 2'd1,
        CFG_GAP         = 2'd2,
        CFG_DEBOUNCE    = 2'd3
    } t_cfg_reg;

    function automatic logic [2:0] mode_led_pattern(input t_mode mode);
        logic [2:0] leds;
        case (mode)
            MODE_EXPLORE: leds = 3'b000;
            MODE_TRY1:    leds = 3'b001;
            MODE_TRY2:    leds = 3'b010;
            MODE_TRY3:    leds = 3'b100;
            MODE_RUN:     leds = 3'b111;
            default:      leds = 3'b000;
        endcase
        return leds;
    endfunction

endpackage

/* hdl/blink_code_and_mode_buttons.sv */
// ----------------------------------------------------------------------------
// blink_code_and_mode_buttons: status blink code and debounced mode buttons
// Shows a status code as LED blinks and steps a mode from two buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one transaction per item: a time
//   tick with the two active-low button levels, a new status message, or a
//   direct mode write. Every item gives exactly one result transaction on the
//   output channel (o_valid / i_stall) with the LED and mode state after it.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the
//   toggle periods, the gap and the debounce time; write them while idle.
//   The accepted item is held in the input register, then the state update
//   writes the block state and the result register, which drives o_valid.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the single state update stage; the state for the next item is ready at
//   the edge that registers the result.
//   Reset (synchronous, active low) empties both registers, clears the mode
//   and message state and loads the default periods.
//   When the receiver stalls, the result is held; the input register still
//   fills, and o_stall rises only when both stages hold a transaction.
// ----------------------------------------------------------------------------
module blink_code_and_mode_buttons #(
    parameter int TIME_BITS = bcmb_pkg::TIME_BITS_DEF,
    parameter int CODE_BITS = bcmb_pkg::CODE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [bcmb_pkg::NOW_W-1:0] i_now_ms,
    input  logic                       i_try_button_level,
    input  logic                       i_run_button_level,
    input  logic [bcmb_pkg::CODE_W-1:0] i_message_code,
    input  logic                       i_message_fast,
    input  logic [2:0]                 i_mode_value,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_status_led,
    output logic [2:0]                 o_mode_leds,
    output logic [2:0]                 o_mode,
    output logic                       o_in_gap,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bcmb_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int NOW_USED = (TIME_BITS < bcmb_pkg::NOW_W) ? TIME_BITS : bcmb_pkg::NOW_W;

    // configuration
    logic [bcmb_pkg::CFG_W-1:0] r_fast_toggle, r_slow_toggle, r_gap_ms, r_debounce;

    // input register
    logic                         r_in_valid;
    bcmb_pkg::t_action            r_action;
    logic [bcmb_pkg::NOW_W-1:0]   r_now;
    logic                         r_try_lvl, r_run_lvl;
    logic [CODE_BITS-1:0]         r_msg_code;
    logic                         r_msg_fast;
    logic [2:0]                   r_mode_value;

    // block state
    bcmb_pkg::t_mode              r_mode, n_mode;
    logic [CODE_BITS-1:0]         r_code, n_code;
    logic                         r_fast, n_fast;
    logic [CODE_BITS-1:0]         r_blinks, n_blinks;
    logic                         r_led, n_led;
    logic                         r_gap, n_gap;
    logic [TIME_BITS-1:0]         r_last_toggle, n_last_toggle;
    logic                         r_try_prev, n_try_prev;
    logic                         r_run_prev, n_run_prev;
    logic [TIME_BITS-1:0]         r_try_time, n_try_time;
    logic [TIME_BITS-1:0]         r_run_time, n_run_time;

    // result register
    logic                         r_out_valid;
    logic                         r_out_led;
    logic [2:0]                   r_out_mode_leds;
    logic [2:0]                   r_out_mode;
    logic                         r_out_gap;

    logic                         w_out_load, w_in_load, w_fire;
    logic [TIME_BITS-1:0]         w_now, w_el_toggle, w_el_try, w_el_run, w_period;
    logic [CODE_BITS:0]           w_blinks_inc;
    logic                         w_try_press, w_run_press;

    // ---- handshake ----
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_in_load  = !r_in_valid || w_out_load;
    assign w_fire     = r_in_valid && w_out_load;
    assign o_stall    = !w_in_load;
    assign o_cfg_ready = 1'b1;

    // ---- time arithmetic, modulo 2^TIME_BITS ----
    assign w_now       = TIME_BITS'(r_now[NOW_USED-1:0]);
    assign w_el_toggle = w_now - r_last_toggle;
    assign w_el_try    = w_now - r_try_time;
    assign w_el_run    = w_now - r_run_time;
    assign w_period    = TIME_BITS'(r_fast ? r_fast_toggle : r_slow_toggle);
    assign w_blinks_inc = {1'b0, r_blinks} + (CODE_BITS+1)'(1);

    assign w_try_press = !r_try_lvl && r_try_prev && (w_el_try > TIME_BITS'(r_debounce));
    assign w_run_press = !r_run_lvl && r_run_prev && (w_el_run > TIME_BITS'(r_debounce));

    // ---- state update ----
    always_comb begin
        n_mode        = r_mode;
        n_code        = r_code;
        n_fast        = r_fast;
        n_blinks      = r_blinks;
        n_led         = r_led;
        n_gap         = r_gap;
        n_last_toggle = r_last_toggle;
        n_try_prev    = r_try_prev;
        n_run_prev    = r_run_prev;
        n_try_time    = r_try_time;
        n_run_time    = r_run_time;
        case (r_action)
            bcmb_pkg::ACT_TICK: begin
                if (r_code != '0) begin
                    if (r_gap) begin
                        if (w_el_toggle >= TIME_BITS'(r_gap_ms)) begin
                            n_gap         = 1'b0;
                            n_blinks      = '0;
                            n_last_toggle = w_now;
                        end
                    end else if (w_el_toggle >= w_period) begin
                        n_last_toggle = w_now;
                        if (r_led) begin
                            n_led    = 1'b0;
                            n_blinks = w_blinks_inc[CODE_BITS-1:0];
                            if (w_blinks_inc >= {1'b0, r_code}) begin
                                n_gap = 1'b1;
                            end
                        end else begin
                            n_led = 1'b1;
                        end
                    end
                end
                // try step first, run overrides on the same tick
                if (w_try_press) begin
                    n_try_time = w_now;
                    if (r_mode == bcmb_pkg::MODE_EXPLORE || r_mode == bcmb_pkg::MODE_TRY1 ||
                        r_mode == bcmb_pkg::MODE_TRY2) begin
                        n_mode = bcmb_pkg::t_mode'(3'(r_mode + 3'd1));
                    end else begin
                        n_mode = bcmb_pkg::MODE_EXPLORE;
                    end
                end
                n_try_prev = r_try_lvl;
                if (w_run_press) begin
                    n_run_time = w_now;
                    n_mode     = bcmb_pkg::MODE_RUN;
                end
                n_run_prev = r_run_lvl;
            end
            bcmb_pkg::ACT_MESSAGE: begin
                // same code: drop the message entirely
                if (r_msg_code != r_code) begin
                    n_code   = r_msg_code;
                    n_fast   = r_msg_fast;
                    n_blinks = '0;
                    n_led    = 1'b0;
                    n_gap    = 1'b0;
                end
            end
            bcmb_pkg::ACT_MODE: begin
                if (r_mode_value <= 3'(bcmb_pkg::MODE_RUN)) begin
                    n_mode = bcmb_pkg::t_mode'(r_mode_value);
                end
            end
            default: begin
            end
        endcase
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_action     <= bcmb_pkg::t_action'(i_action);
            r_now        <= i_now_ms;
            r_try_lvl    <= i_try_button_level;
            r_run_lvl    <= i_run_button_level;
            r_msg_code   <= i_message_code[CODE_BITS-1:0];
            r_msg_fast   <= i_message_fast;
            r_mode_value <= i_mode_value;
        end
    end

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_toggle <= bcmb_pkg::FAST_TOGGLE_RST;
            r_slow_toggle <= bcmb_pkg::SLOW_TOGGLE_RST;
            r_gap_ms      <= bcmb_pkg::GAP_RST;
            r_debounce    <= bcmb_pkg::DEBOUNCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bcmb_pkg::t_cfg_reg'(i_cfg_index))
                bcmb_pkg::CFG_FAST_TOGGLE: r_fast_toggle <= i_cfg_data;
                bcmb_pkg::CFG_SLOW_TOGGLE: r_slow_toggle <= i_cfg_data;
                bcmb_pkg::CFG_GAP:         r_gap_ms      <= i_cfg_data;
                bcmb_pkg::CFG_DEBOUNCE:    r_debounce    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---- block state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= bcmb_pkg::MODE_EXPLORE;
            r_code        <= '0;
            r_fast        <= 1'b0;
            r_blinks      <= '0;
            r_led         <= 1'b0;
            r_gap         <= 1'b0;
            r_last_toggle <= '0;
            r_try_prev    <= 1'b1;
            r_run_prev    <= 1'b1;
            r_try_time    <= '0;
            r_run_time    <= '0;
        end else if (w_fire) begin
            r_mode        <= n_mode;
            r_code        <= n_code;
            r_fast        <= n_fast;
            r_blinks      <= n_blinks;
            r_led         <= n_led;
            r_gap         <= n_gap;
            r_last_toggle <= n_last_toggle;
            r_try_prev    <= n_try_prev;
            r_run_prev    <= n_run_prev;
            r_try_time    <= n_try_time;
            r_run_time    <= n_run_time;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_led       <= (n_code != '0) && n_led;
            r_out_mode_leds <= bcmb_pkg::mode_led_pattern(n_mode);
            r_out_mode      <= n_mode;
            r_out_gap       <= n_gap;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status_led = r_out_led;
    assign o_mode_leds  = r_out_mode_leds;
    assign o_mode       = r_out_mode;
    assign o_in_gap     = r_out_gap;

`ifndef NO_ASSERTIONS
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= bcmb_pkg::MODE_RUN)
        else $error("mode register out of range");

    a_gap_led_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> !r_led)
        else $error("LED lit during gap");

    a_blinks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blinks <= r_code)
        else $error("blink count beyond shown code");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_leds_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode_leds ==
            bcmb_pkg::mode_led_pattern(bcmb_pkg::t_mode'(o_mode))))
        else $error("mode LEDs do not match mode");
`endif

endmodule

/* test/blink_mode_checker.sv */
// ----------------------------------------------------------------------------
// blink_mode_checker: predicts and checks blink code and mode results
// Watches the configuration, input and result channels. It keeps its own
// copy of the registers, the blink sequencer and the button debouncers, and
// predicts the display state after every accepted input transaction. Each
// accepted result is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module blink_mode_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    input  logic                        i_stall_in,
    input  logic [1:0]                  i_action,
    input  logic [bcmb_pkg::NOW_W-1:0]  i_now_ms,
    input  logic                        i_try_button_level,
    input  logic                        i_run_button_level,
    input  logic [bcmb_pkg::CODE_W-1:0] i_message_code,
    input  logic                        i_message_fast,
    input  logic [2:0]                  i_mode_value,
    // result channel
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic                        i_status_led,
    input  logic [2:0]                  i_mode_leds,
    input  logic [2:0]                  i_mode,
    input  logic                        i_in_gap,
    // configuration channel
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [bcmb_pkg::CFG_W-1:0]  i_cfg_data,
    // status to the testbench top
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            status_led;
        logic [2:0]      mode_leds;
        bcmb_pkg::t_mode mode;
        logic            in_gap;
    } t_display;

    t_display display_q[$];

    logic [bcmb_pkg::CFG_W-1:0]  fast_ms, slow_ms, gap_ms, debounce_ms;
    bcmb_pkg::t_mode             mode_now;
    logic [bcmb_pkg::CODE_W-1:0] code_shown;
    logic                        fast_sel;
    logic [bcmb_pkg::CODE_W-1:0] blinks;
    logic                        lit;
    logic                        pausing;
    logic [bcmb_pkg::NOW_W-1:0]  last_toggle;
    logic                        try_prev, run_prev;
    logic [bcmb_pkg::NOW_W-1:0]  try_at, run_at;

    task automatic clear_indicator();
        fast_ms     = bcmb_pkg::FAST_TOGGLE_RST;
        slow_ms     = bcmb_pkg::SLOW_TOGGLE_RST;
        gap_ms      = bcmb_pkg::GAP_RST;
        debounce_ms = bcmb_pkg::DEBOUNCE_RST;
        mode_now    = bcmb_pkg::MODE_EXPLORE;
        code_shown  = '0;
        fast_sel    = 1'b0;
        blinks      = '0;
        lit         = 1'b0;
        pausing     = 1'b0;
        last_toggle = '0;
        try_prev    = 1'b1;
        run_prev    = 1'b1;
        try_at      = '0;
        run_at      = '0;
    endtask

    // Advance the blink sequencer and the two debounced buttons on one tick.
    task automatic tick_indicator(input logic [bcmb_pkg::NOW_W-1:0] now,
                                  input logic try_lvl, input logic run_lvl);
        logic [bcmb_pkg::NOW_W-1:0] since_toggle;
        logic [bcmb_pkg::NOW_W-1:0] period;
        since_toggle = now - last_toggle;
        period       = fast_sel ? {16'd0, fast_ms} : {16'd0, slow_ms};
        if (code_shown != '0) begin
            if (pausing) begin
                if (since_toggle >= {16'd0, gap_ms}) begin
                    pausing     = 1'b0;
                    blinks      = '0;
                    last_toggle = now;
                end
            end else if (since_toggle >= period) begin
                last_toggle = now;
                if (lit) begin
                    lit    = 1'b0;
                    blinks = blinks + 8'd1;
                    if (blinks >= code_shown)
                        pausing = 1'b1;
                end else begin
                    lit = 1'b1;
                end
            end
        end
        // try steps first so that a run press on the same tick wins
        if (!try_lvl && try_prev && ((now - try_at) > {16'd0, debounce_ms})) begin
            try_at   = now;
            mode_now = (mode_now < bcmb_pkg::MODE_TRY3) ?
                       bcmb_pkg::t_mode'(mode_now + 3'd1) : bcmb_pkg::MODE_EXPLORE;
        end
        try_prev = try_lvl;
        if (!run_lvl && run_prev && ((now - run_at) > {16'd0, debounce_ms})) begin
            run_at   = now;
            mode_now = bcmb_pkg::MODE_RUN;
        end
        run_prev = run_lvl;
    endtask

    function automatic t_display display_now();
        t_display d;
        d.status_led = (code_shown != '0) ? lit : 1'b0;
        case (mode_now)
            bcmb_pkg::MODE_TRY1: d.mode_leds = 3'b001;
            bcmb_pkg::MODE_TRY2: d.mode_leds = 3'b010;
            bcmb_pkg::MODE_TRY3: d.mode_leds = 3'b100;
            bcmb_pkg::MODE_RUN:  d.mode_leds = 3'b111;
            default:             d.mode_leds = 3'b000;
        endcase
        d.mode   = mode_now;
        d.in_gap = pausing;
        return d;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_errors = o_errors + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            clear_indicator();
            display_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bcmb_pkg::CFG_FAST_TOGGLE: fast_ms     = i_cfg_data;
                    bcmb_pkg::CFG_SLOW_TOGGLE: slow_ms     = i_cfg_data;
                    bcmb_pkg::CFG_GAP:         gap_ms      = i_cfg_data;
                    bcmb_pkg::CFG_DEBOUNCE:    debounce_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // retire the result before taking a new transaction in
            if (i_res_valid === 1'b1 && i_res_stall === 1'b0) begin
                if (display_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "actual led/leds/mode/gap", i_status_led,
                             i_mode_leds, i_mode, i_in_gap);
                    o_errors = o_errors + 1;
                end else begin
                    want = display_q.pop_front();
                    check_field("status_led", 8'(want.status_led), 8'(i_status_led));
                    check_field("mode_leds", 8'(want.mode_leds), 8'(i_mode_leds));
                    check_field("mode", 8'(want.mode), 8'(i_mode));
                    check_field("in_gap", 8'(want.in_gap), 8'(i_in_gap));
                end
            end
            if (i_valid === 1'b1 && i_stall_in === 1'b0) begin
                case (i_action)
                    bcmb_pkg::ACT_TICK: tick_indicator(i_now_ms, i_try_button_level,
                                                       i_run_button_level);
                    bcmb_pkg::ACT_MESSAGE: begin
                        if (i_message_code != code_shown) begin
                            code_shown = i_message_code;
                            fast_sel   = i_message_fast;
                            blinks     = '0;
                            lit        = 1'b0;
                            pausing    = 1'b0;
                        end
                    end
                    bcmb_pkg::ACT_MODE: begin
                        if (i_mode_value <= bcmb_pkg::MODE_RUN)
                            mode_now = bcmb_pkg::t_mode'(i_mode_value);
                    end
                    default: ;
                endcase
                display_q.push_back(display_now());
            end
        end
        o_pending = display_q.size();
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the blink code and mode buttons block
// Drives ticks, status messages and mode writes with random idle gaps on
// both channels, through several register settings including the extremes.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // action code the block ignores
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [1:0]                  i_action = bcmb_pkg::ACT_TICK;
    logic [bcmb_pkg::NOW_W-1:0]  i_now_ms = '0;
    logic                        i_try_button_level = 1'b1;
    logic                        i_run_button_level = 1'b1;
    logic [bcmb_pkg::CODE_W-1:0] i_message_code = '0;
    logic                        i_message_fast = 1'b0;
    logic [2:0]                  i_mode_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic                        o_status_led;
    logic [2:0]                  o_mode_leds;
    logic [2:0]                  o_mode;
    logic                        o_in_gap;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [1:0]                  i_cfg_index = bcmb_pkg::CFG_FAST_TOGGLE;
    logic [bcmb_pkg::CFG_W-1:0]  i_cfg_data = '0;

    int errors;
    int pending_count;
    int send_calm = 0;
    int recv_calm = 0;

    logic [bcmb_pkg::NOW_W-1:0]  wall_ms = '0;
    logic                        try_lvl = 1'b1;
    logic                        run_lvl = 1'b1;
    logic [bcmb_pkg::CODE_W-1:0] last_code = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    blink_code_and_mode_buttons i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_now_ms           (i_now_ms),
        .i_try_button_level (i_try_button_level),
        .i_run_button_level (i_run_button_level),
        .i_message_code     (i_message_code),
        .i_message_fast     (i_message_fast),
        .i_mode_value       (i_mode_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status_led       (o_status_led),
        .o_mode_leds        (o_mode_leds),
        .o_mode             (o_mode),
        .o_in_gap           (o_in_gap),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    blink_mode_checker i_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_stall_in         (o_stall),
        .i_action           (i_action),
        .i_now_ms           (i_now_ms),
        .i_try_button_level (i_try_button_level),
        .i_run_button_level (i_run_button_level),
        .i_message_code     (i_message_code),
        .i_message_fast     (i_message_fast),
        .i_mode_value       (i_mode_value),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_status_led       (o_status_led),
        .i_mode_leds        (o_mode_leds),
        .i_mode             (o_mode),
        .i_in_gap           (o_in_gap),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_errors           (errors),
        .o_pending          (pending_count)
    );

    // Draw a random idle wait, with occasional stretches of back-to-back traffic.
    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0) begin
            calm   = calm - 1;
            cycles = 0;
        end else if ($urandom_range(0, 24) == 0) begin
            calm   = $urandom_range(8, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 18);
        end
    endtask

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input logic [1:0] act, input logic [bcmb_pkg::NOW_W-1:0] now,
                             input logic try_l, input logic run_l,
                             input logic [bcmb_pkg::CODE_W-1:0] code, input logic fast,
                             input logic [2:0] mode_val);
        int idle;
        draw_wait(send_calm, idle);
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_action           <= act;
        i_now_ms           <= now;
        i_try_button_level <= try_l;
        i_run_button_level <= run_l;
        i_message_code     <= code;
        i_message_fast     <= fast;
        i_mode_value       <= mode_val;
        i_valid            <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic tick(input logic [bcmb_pkg::NOW_W-1:0] now, input logic try_l,
                        input logic run_l);
        send_item(bcmb_pkg::ACT_TICK, now, try_l, run_l, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    task automatic write_reg(input bcmb_pkg::t_cfg_reg idx,
                             input logic [bcmb_pkg::CFG_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [bcmb_pkg::CFG_W-1:0] fast,
                             input logic [bcmb_pkg::CFG_W-1:0] slow,
                             input logic [bcmb_pkg::CFG_W-1:0] gap,
                             input logic [bcmb_pkg::CFG_W-1:0] debounce);
        write_reg(bcmb_pkg::CFG_FAST_TOGGLE, fast);
        write_reg(bcmb_pkg::CFG_SLOW_TOGGLE, slow);
        write_reg(bcmb_pkg::CFG_GAP, gap);
        write_reg(bcmb_pkg::CFG_DEBOUNCE, debounce);
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
    endtask

    // Mostly ticks with a time that moves forward, button levels that toggle,
    // short blink codes so that the gap is reached, plus noise.
    task automatic run_random(input int count, input int step_max);
        int n;
        int pick;
        logic [1:0] act;
        logic [bcmb_pkg::CODE_W-1:0] code;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 82)      act = bcmb_pkg::ACT_TICK;
            else if (pick < 89) act = bcmb_pkg::ACT_MESSAGE;
            else if (pick < 97) act = bcmb_pkg::ACT_MODE;
            else                act = ACT_NONE;
            if ($urandom_range(0, 49) == 0) wall_ms = $urandom;
            else wall_ms = wall_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 2) == 0) try_lvl = ~try_lvl;
            if ($urandom_range(0, 5) == 0) run_lvl = ~run_lvl;
            pick = $urandom_range(0, 9);
            if (pick == 0)      code = '0;
            else if (pick == 1) code = last_code;
            else if (pick == 2) code = 8'($urandom_range(0, 255));
            else                code = 8'($urandom_range(1, 4));
            if (act == bcmb_pkg::ACT_MESSAGE) last_code = code;
            send_item(act, wall_ms, try_lvl, run_lvl, code, 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
        end
    endtask

    always begin
        int idle;
        @(negedge i_clk);
        draw_wait(recv_calm, idle);
        if (idle > 0) begin
            i_stall <= 1'b1;
            repeat (idle) @(negedge i_clk);
        end
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (o_valid !== 1'b1) @(posedge i_clk);
    end

    initial begin
        int p;
        int f, s;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset register values
        tick(32'd0, 1'b1, 1'b1);
        send_item(bcmb_pkg::ACT_MESSAGE, 32'd0, 1'b1, 1'b1, 8'd2, 1'b0, 3'd0);
        // same code again: fast select must not be taken
        send_item(bcmb_pkg::ACT_MESSAGE, 32'd0, 1'b1, 1'b1, 8'd2, 1'b1, 3'd0);
        tick(32'd249, 1'b1, 1'b1);
        tick(32'd250, 1'b1, 1'b1);
        tick(32'd500, 1'b1, 1'b1);
        tick(32'd750, 1'b1, 1'b1);
        tick(32'd1000, 1'b1, 1'b1);
        tick(32'd1999, 1'b1, 1'b1);
        tick(32'd2000, 1'b1, 1'b1);
        tick(32'd2010, 1'b0, 1'b1);
        tick(32'd2020, 1'b1, 1'b1);
        // second press inside the debounce window
        tick(32'd2040, 1'b0, 1'b1);
        tick(32'd2100, 1'b1, 1'b1);
        // both buttons on one tick: run wins
        tick(32'd2200, 1'b0, 1'b0);
        tick(32'd2300, 1'b1, 1'b1);
        tick(32'd2400, 1'b0, 1'b1);
        send_item(bcmb_pkg::ACT_MODE, 32'd0, 1'b1, 1'b1, 8'd0, 1'b0, 3'd7);
        send_item(bcmb_pkg::ACT_MODE, 32'd0, 1'b1, 1'b1, 8'd0, 1'b0, bcmb_pkg::MODE_TRY3);
        send_item(ACT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'hFF, 1'b1, 3'd7);
        send_item(bcmb_pkg::ACT_MESSAGE, 32'd0, 1'b1, 1'b1, 8'd0, 1'b1, 3'd0);
        send_item(bcmb_pkg::ACT_MESSAGE, 32'd0, 1'b1, 1'b1, 8'd255, 1'b1, 3'd0);
        tick(32'hFFFF_FFF0, 1'b1, 1'b1);
        tick(32'hFFFF_FFFF, 1'b0, 1'b1);
        // time wraps past zero
        tick(32'h0000_0100, 1'b1, 1'b0);
        wall_ms   = 32'h0000_0100;
        last_code = 8'd255;

        run_random(400, 600);

        settle();
        configure(16'd1, 16'd2, 16'd1, 16'd0);
        run_random(250, 5);

        // zero periods and gap end on the next tick
        settle();
        configure(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(100, 3);

        settle();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(250, 140000);

        for (p = 0; p < 3; p++) begin
            settle();
            f = $urandom_range(1, 300);
            s = $urandom_range(1, 600);
            configure(16'(f), 16'(s), 16'($urandom_range(1, 1500)),
                      16'($urandom_range(0, 200)));
            run_random(230, 2 * ((f > s) ? f : s));
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
